>>> hdl/swtg_pkg.sv
`default_nettype none

package swtg_pkg;

    localparam int CounterBits  = 16;
    localparam int ClockBits    = 27;
    localparam int FreqBits     = 16;
    localparam int TicksBits    = ClockBits - 1;
    localparam int PrescaleBits = 10;
    localparam int CodeBits     = 3;
    localparam int OpBits       = 2;
    localparam int StepBits     = $clog2(ClockBits);

    localparam logic [StepBits-1:0]  LastStep   = StepBits'(ClockBits - 1);
    localparam logic [ClockBits-1:0] ClockReset = ClockBits'(16000000);

    // Half-period limits above which the next larger prescaler is used.
    localparam logic [TicksBits-1:0] Limit1024 = TicksBits'(8388607);
    localparam logic [TicksBits-1:0] Limit256  = TicksBits'(2097151);
    localparam logic [TicksBits-1:0] Limit64   = TicksBits'(524287);
    localparam logic [TicksBits-1:0] Limit8    = TicksBits'(65535);

    typedef enum logic [OpBits-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [CodeBits-1:0] {
        PS_1    = 3'd0,
        PS_8    = 3'd1,
        PS_64   = 3'd2,
        PS_256  = 3'd3,
        PS_1024 = 3'd4
    } prescale_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic exec;
        logic div_load;
        logic div_step;
        logic commit;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_div;
    } dp_status_t;

    // Terminal value of the prescale counter for each prescaler setting.
    function automatic logic [PrescaleBits-1:0] prescale_last(input prescale_t code);
        logic [PrescaleBits-1:0] last;
        unique case (code)
            PS_8:    last = PrescaleBits'(7);
            PS_64:   last = PrescaleBits'(63);
            PS_256:  last = PrescaleBits'(255);
            PS_1024: last = PrescaleBits'(1023);
            default: last = '0;
        endcase
        return last;
    endfunction

endpackage

`default_nettype wire

>>> hdl/swtg_if.sv
`default_nettype none

interface swtg_in_if;
    logic                            valid;
    logic                            ready;
    logic [swtg_pkg::OpBits-1:0]     operation;
    logic [swtg_pkg::FreqBits-1:0]   frequency_hz;

    modport source (output valid, operation, frequency_hz, input ready);
    modport sink   (input valid, operation, frequency_hz, output ready);
endinterface

interface swtg_out_if;
    logic                             valid;
    logic                             ready;
    logic                             pin_level;
    logic                             pin_driven;
    logic                             running;
    logic [swtg_pkg::CounterBits-1:0] compare_value;
    logic [swtg_pkg::CodeBits-1:0]    prescale_select;

    modport source (output valid, pin_level, pin_driven, running, compare_value,
                    prescale_select, input ready);
    modport sink   (input valid, pin_level, pin_driven, running, compare_value,
                    prescale_select, output ready);
endinterface

`default_nettype wire

>>> hdl/swtg_ctrl.sv
`default_nettype none

module swtg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  swtg_pkg::dp_status_t   status,
    output swtg_pkg::ctrl_cmd_t    cmd
);

    swtg_pkg::state_t                 state_reg, state_next;
    logic [swtg_pkg::StepBits-1:0]    step_reg, step_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swtg_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            swtg_pkg::ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (status.start_div)
                    begin
                        cmd.div_load = 1'b1;
                        step_next    = '0;
                        state_next   = swtg_pkg::ST_DIVIDE;
                    end
                    else
                    begin
                        cmd.exec     = 1'b1;
                        cmd.load_out = 1'b1;
                    end
                end
            end
            swtg_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == swtg_pkg::LastStep)
                begin
                    state_next = swtg_pkg::ST_FINISH;
                end
            end
            swtg_pkg::ST_FINISH:
            begin
                // The new settings land together with their result.
                if (out_free)
                begin
                    cmd.commit   = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = swtg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swtg_pkg::ST_IDLE;
            end
        endcase

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

`default_nettype wire

>>> hdl/swtg_dp.sv
`default_nettype none

module swtg_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [swtg_pkg::ClockBits-1:0]    cfg_wr_data,
    input  logic [swtg_pkg::OpBits-1:0]       operation,
    input  logic [swtg_pkg::FreqBits-1:0]     frequency_hz,
    input  swtg_pkg::ctrl_cmd_t               cmd,
    output swtg_pkg::dp_status_t              status,
    output logic                              pin_level,
    output logic                              pin_driven,
    output logic                              running,
    output logic [swtg_pkg::CounterBits-1:0]  compare_value,
    output logic [swtg_pkg::CodeBits-1:0]     prescale_select
);

    localparam int CB = swtg_pkg::ClockBits;
    localparam int FB = swtg_pkg::FreqBits;
    localparam int TB = swtg_pkg::TicksBits;
    localparam int NB = swtg_pkg::CounterBits;
    localparam int PB = swtg_pkg::PrescaleBits;

    logic [CB-1:0]          clock_hz_reg;

    logic                   level_reg, level_next;
    logic                   driven_reg, driven_next;
    logic                   enabled_reg, enabled_next;
    swtg_pkg::prescale_t    code_reg, code_next;
    logic [NB-1:0]          match_reg, match_next;
    logic [NB-1:0]          count_reg, count_next;
    logic [PB-1:0]          pscount_reg, pscount_next;

    logic [FB-1:0]          divisor_reg;
    logic [FB-1:0]          rem_reg;
    logic [CB-1:0]          quot_reg;

    logic                   out_level_reg;
    logic                   out_driven_reg;
    logic                   out_running_reg;
    logic [NB-1:0]          out_compare_reg;
    swtg_pkg::prescale_t    out_code_reg;

    logic [FB:0]            rem_shift;
    logic [FB:0]            rem_diff;
    logic                   quot_bit;
    logic [TB-1:0]          ticks;
    logic [TB-1:0]          scaled;
    logic [TB-1:0]          scaled_m1;
    swtg_pkg::prescale_t    new_code;

    assign status.start_div = (operation == swtg_pkg::OP_START) && (frequency_hz != '0);

    // Restoring divider: one quotient bit of clock / frequency per step.
    assign rem_shift = {rem_reg, quot_reg[CB-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign quot_bit  = (rem_shift >= {1'b0, divisor_reg});

    assign ticks = quot_reg[CB-1:1];

    always_comb
    begin
        priority if (ticks > swtg_pkg::Limit1024)
        begin
            scaled   = ticks >> 10;
            new_code = swtg_pkg::PS_1024;
        end
        else if (ticks > swtg_pkg::Limit256)
        begin
            scaled   = ticks >> 8;
            new_code = swtg_pkg::PS_256;
        end
        else if (ticks > swtg_pkg::Limit64)
        begin
            scaled   = ticks >> 6;
            new_code = swtg_pkg::PS_64;
        end
        else if (ticks > swtg_pkg::Limit8)
        begin
            scaled   = ticks >> 3;
            new_code = swtg_pkg::PS_8;
        end
        else
        begin
            scaled   = ticks;
            new_code = swtg_pkg::PS_1;
        end
        scaled_m1 = scaled - TB'(1);
    end

    always_comb
    begin
        level_next   = level_reg;
        driven_next  = driven_reg;
        enabled_next = enabled_reg;
        code_next    = code_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        pscount_next = pscount_reg;

        if (cmd.exec)
        begin
            unique case (operation)
                swtg_pkg::OP_TICK:
                begin
                    if (enabled_reg)
                    begin
                        if (pscount_reg >= swtg_pkg::prescale_last(code_reg))
                        begin
                            pscount_next = '0;
                            if (count_reg == match_reg)
                            begin
                                count_next = '0;
                                level_next = !level_reg;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            pscount_next = pscount_reg + 1'b1;
                        end
                    end
                end
                swtg_pkg::OP_STOP:
                begin
                    driven_next  = 1'b0;
                    enabled_next = 1'b0;
                end
                default:
                begin
                    // A start with zero frequency and the unused code change nothing.
                end
            endcase
        end

        if (cmd.commit)
        begin
            code_next    = new_code;
            match_next   = scaled_m1[NB-1:0];
            driven_next  = 1'b1;
            enabled_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= swtg_pkg::ClockReset;
            level_reg    <= 1'b0;
            driven_reg   <= 1'b0;
            enabled_reg  <= 1'b0;
            code_reg     <= swtg_pkg::PS_1;
            match_reg    <= '0;
            count_reg    <= '0;
            pscount_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                clock_hz_reg <= cfg_wr_data;
            end
            level_reg   <= level_next;
            driven_reg  <= driven_next;
            enabled_reg <= enabled_next;
            code_reg    <= code_next;
            match_reg   <= match_next;
            count_reg   <= count_next;
            pscount_reg <= pscount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            divisor_reg <= frequency_hz;
            rem_reg     <= '0;
            quot_reg    <= clock_hz_reg;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= quot_bit ? rem_diff[FB-1:0] : rem_shift[FB-1:0];
            quot_reg <= {quot_reg[CB-2:0], quot_bit};
        end

        if (cmd.load_out)
        begin
            out_level_reg   <= level_next;
            out_driven_reg  <= driven_next;
            out_running_reg <= enabled_next;
            out_compare_reg <= match_next;
            out_code_reg    <= code_next;
        end
    end

    assign pin_level       = out_level_reg;
    assign pin_driven      = out_driven_reg;
    assign running         = out_running_reg;
    assign compare_value   = out_compare_reg;
    assign prescale_select = out_code_reg;

endmodule

`default_nettype wire

>>> hdl/square_wave_tone_generator.sv
// Square-wave tone generator with a clear-on-compare timer.
// Requests arrive on in_req (operation, frequency_hz): tick advances the
// prescaler and timer by one clock while a tone runs, start with a nonzero
// frequency programs a tone and connects the pin, stop releases the pin and
// halts counting. Every request yields one result on out_res that shows the
// level, pin, run state, compare value and prescaler code after the request.
// Tick, stop and ignored requests: the result is valid the cycle after
// acceptance, and one such request is taken every cycle unless the
// receiver stalls. A start with a nonzero frequency runs a bit-serial
// divider of the clock register by the frequency, 27 steps, then loads the
// timer once the result register is free; ready stays low meanwhile.
// cfg_wr_en/cfg_wr_data write the clock frequency register; write it only
// while no request is in flight.
// Reset sets the clock register to 16 MHz, clears all timer state and drops
// out_res.valid. When the receiver stalls, the result register holds its
// value and a new request is taken only in a cycle in which the pending
// result leaves.
`default_nettype none

module square_wave_tone_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [swtg_pkg::ClockBits-1:0]  cfg_wr_data,
    swtg_in_if.sink                         in_req,
    swtg_out_if.source                      out_res
);

    swtg_pkg::ctrl_cmd_t   cmd;
    swtg_pkg::dp_status_t  status;
    logic                  in_ready;
    logic                  out_valid;

    swtg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_res.ready),
        .status    (status),
        .cmd       (cmd)
    );

    swtg_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .operation       (in_req.operation),
        .frequency_hz    (in_req.frequency_hz),
        .cmd             (cmd),
        .status          (status),
        .pin_level       (out_res.pin_level),
        .pin_driven      (out_res.pin_driven),
        .running         (out_res.running),
        .compare_value   (out_res.compare_value),
        .prescale_select (out_res.prescale_select)
    );

    assign in_req.ready  = in_ready;
    assign out_res.valid = out_valid;

    // A start that needs the divider blocks further requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_req.valid && in_ready && in_req.operation == swtg_pkg::OP_START
         && in_req.frequency_hz != '0) |=> !in_ready)
    else $error("request accepted while the divider is busy");

    // Loading a tone reports a driven, running pin.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid && out_res.running && out_res.pin_driven))
    else $error("start result does not show a running tone");

    // A stop reports a released, halted pin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_req.valid && in_ready && in_req.operation == swtg_pkg::OP_STOP)
        |=> (out_valid && !out_res.running && !out_res.pin_driven))
    else $error("stop result still shows a running tone");

    // Divider commands only occur while no result is being loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_load || cmd.div_step) |-> !cmd.load_out && !cmd.exec)
    else $error("divider active together with an operation");

endmodule

`default_nettype wire

>>> tb/sv/square_wave_tone_generator_tb.sv
`default_nettype none

module square_wave_tone_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swtg_pkg::*;

    typedef struct packed {
        logic                   level;
        logic                   driven;
        logic                   running;
        logic [CounterBits-1:0] compare;
        logic [CodeBits-1:0]    code;
    } tone_status_t;

    localparam logic [OpBits-1:0] OpUnused = 2'd3;

    // Half-period counts above which the tone needs a coarser prescaler.
    localparam int unsigned Over1024 = 8388607;
    localparam int unsigned Over256  = 2097151;
    localparam int unsigned Over64   = 524287;
    localparam int unsigned Over8    = 65535;

    localparam int MaxReports    = 10;
    localparam int HoldOffCycles = 300;
    localparam int PressureItems = 40;
    localparam int SettleCycles  = 40;
    localparam int BlockItems    = 150;
    localparam int NumBlocks     = 8;

    class tone_tracker;
        logic [ClockBits-1:0]    clock_hz;
        logic                    level;
        logic                    driven;
        logic                    enabled;
        prescale_t               code;
        logic [CounterBits-1:0]  match_value;
        logic [CounterBits-1:0]  timer_count;
        logic [PrescaleBits-1:0] prescale_count;
        tone_status_t            pending_status[$];
        int                      mismatches;

        function new();
            clock_hz       = ClockReset;
            level          = 1'b0;
            driven         = 1'b0;
            enabled        = 1'b0;
            code           = PS_1;
            match_value    = '0;
            timer_count    = '0;
            prescale_count = '0;
            mismatches     = 0;
        endfunction

        function void set_clock(input logic [ClockBits-1:0] hz);
            clock_hz = hz;
        endfunction

        // Applies one accepted request and queues the status it must report.
        function void advance_tone(input logic [OpBits-1:0] op,
                                   input logic [FreqBits-1:0] freq);
            int unsigned top;
            int unsigned ticks;
            case (op)
                OP_TICK:
                begin
                    if (enabled)
                    begin
                        case (code)
                            PS_8:    top = 7;
                            PS_64:   top = 63;
                            PS_256:  top = 255;
                            PS_1024: top = 1023;
                            default: top = 0;
                        endcase
                        if (prescale_count >= top)
                        begin
                            prescale_count = '0;
                            if (timer_count == match_value)
                            begin
                                timer_count = '0;
                                level = ~level;
                            end
                            else
                                timer_count++;
                        end
                        else
                            prescale_count++;
                    end
                end
                OP_START:
                begin
                    if (freq != '0)
                    begin
                        ticks = (clock_hz / freq) / 2;
                        if (ticks > Over1024)
                        begin
                            ticks >>= 10;
                            code = PS_1024;
                        end
                        else if (ticks > Over256)
                        begin
                            ticks >>= 8;
                            code = PS_256;
                        end
                        else if (ticks > Over64)
                        begin
                            ticks >>= 6;
                            code = PS_64;
                        end
                        else if (ticks > Over8)
                        begin
                            ticks >>= 3;
                            code = PS_8;
                        end
                        else
                            code = PS_1;
                        // A half-period of zero wraps to the all-ones compare value.
                        match_value = CounterBits'(ticks - 1);
                        driven = 1'b1;
                        enabled = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    driven = 1'b0;
                    enabled = 1'b0;
                end
                default:
                begin
                end
            endcase
            pending_status.push_back(tone_status_t'{level, driven, enabled, match_value, code});
        endfunction

        function void check_result(input tone_status_t got);
            tone_status_t want;
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display("%0t: result %h arrived with no request waiting", $realtime, got);
                return;
            end
            want = pending_status.pop_front();
            if (got.level !== want.level || got.driven !== want.driven ||
                got.running !== want.running || got.compare !== want.compare ||
                got.code !== want.code)
            begin
                mismatches++;
                if (mismatches <= MaxReports)
                    $display({"%0t: expected level=%b driven=%b running=%b compare=%0d ",
                              "prescale=%0d, got level=%b driven=%b running=%b compare=%0d ",
                              "prescale=%0d"}, $realtime,
                             want.level, want.driven, want.running, want.compare, want.code,
                             got.level, got.driven, got.running, got.compare, got.code);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [ClockBits-1:0] cfg_wr_data;
    int                   tx_idle_pct = 0;
    int                   rx_stall_pct = 0;
    int                   hold_off_len = 0;
    tone_tracker          tracker = new();

    swtg_in_if  in_req_if ();
    swtg_out_if out_res_if ();

    square_wave_tone_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_req      (in_req_if),
        .out_res     (out_res_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly fast tones so the pin toggles within a burst of ticks.
    function automatic logic [FreqBits-1:0] pick_tone(input logic [ClockBits-1:0] hz);
        int unsigned r;
        int unsigned lo;
        r = $urandom_range(99);
        lo = hz / 600;
        if (lo < 1)
            lo = 1;
        if (lo > 49152)
            lo = 49152;
        if (r < 3)
            return '0;
        if (r < 50)
            return FreqBits'($urandom);
        return FreqBits'($urandom_range(65535, lo));
    endfunction

    task automatic send_request(input logic [OpBits-1:0] op, input logic [FreqBits-1:0] freq);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_req_if.valid <= 1'b1;
        in_req_if.operation <= op;
        in_req_if.frequency_hz <= freq;
        do
            @(posedge clk);
        while (in_req_if.ready !== 1'b1);
        tracker.advance_tone(op, freq);
    endtask

    task automatic drain();
        in_req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_status.size() != 0);
    endtask

    task automatic write_clock(input logic [ClockBits-1:0] hz);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        tracker.set_clock(hz);
    endtask

    // Each sequence starts a tone and lets it run, with stray requests mixed in.
    task automatic run_block(input int unsigned n_items, input logic [ClockBits-1:0] hz);
        int unsigned sent;
        int unsigned burst;
        int unsigned r;
        sent = 0;
        while (sent < n_items)
        begin
            send_request(OP_START, pick_tone(hz));
            burst = ($urandom_range(11) == 0) ? $urandom_range(400, 150) : $urandom_range(80, 1);
            repeat (burst)
            begin
                r = $urandom_range(99);
                if (r < 92)
                    send_request(OP_TICK, FreqBits'($urandom));
                else if (r < 95)
                    send_request(OP_STOP, FreqBits'($urandom));
                else if (r < 97)
                    send_request(OpUnused, FreqBits'($urandom));
                else
                    send_request(OP_START, pick_tone(hz));
            end
            sent += burst + 1;
        end
    endtask

    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        out_res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_res_if.valid === 1'b1 && out_res_if.ready === 1'b1)
                tracker.check_result(tone_status_t'{out_res_if.pin_level, out_res_if.pin_driven,
                                                    out_res_if.running, out_res_if.compare_value,
                                                    out_res_if.prescale_select});
            if (hold_off_len != 0)
            begin
                hold_left = hold_off_len;
                hold_off_len = 0;
            end
            if (hold_left > 0)
            begin
                out_res_if.ready <= 1'b0;
                hold_left--;
            end
            else
                out_res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [ClockBits-1:0] hz;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_req_if.valid <= 1'b0;
        in_req_if.operation <= OP_TICK;
        in_req_if.frequency_hz <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle requests, ignored start, every prescaler, kept state, wrap.
        write_clock(27'd16000000);
        send_request(OP_TICK, 16'h0000);
        send_request(OpUnused, 16'h0000);
        send_request(OP_STOP, 16'h0000);
        send_request(OP_START, 16'h0000);
        send_request(OP_START, 16'hFFFF);
        repeat (3) send_request(OP_TICK, 16'hFFFF);
        send_request(OP_START, 16'd1);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_START, 16'd20);
        send_request(OP_START, 16'd10);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_STOP, 16'hFFFF);
        send_request(OP_TICK, 16'h0000);
        write_clock(27'd100000000);
        send_request(OP_START, 16'd1);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_START, 16'hFFFF);
        send_request(OP_TICK, 16'h0000);
        write_clock(27'd100000);
        send_request(OP_START, 16'hFFFF);
        send_request(OP_TICK, 16'h0000);
        send_request(OP_START, 16'd30000);
        repeat (2) send_request(OP_TICK, 16'h0000);
        send_request(OpUnused, 16'hFFFF);

        for (int b = 0; b < NumBlocks; b++)
        begin
            case (b)
                0: hz = 27'd16000000;
                1: hz = 27'd1000000;
                2: hz = 27'd100000000;
                3: hz = 27'd100000;
                default: hz = ClockBits'($urandom_range(100000000, 1000000));
            endcase
            write_clock(hz);
            case (b % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 53; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 53; end
                default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
            endcase
            run_block(BlockItems, hz);
            if (b == 1)
            begin
                // Receiver holds off while the sender keeps pushing, then the sender
                // waits for every outstanding result.
                tx_idle_pct = 0;
                hold_off_len = HoldOffCycles;
                repeat (PressureItems) send_request(OP_TICK, FreqBits'($urandom));
                drain();
            end
        end

        drain();
        repeat (SettleCycles) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.pending_status.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/swtg_pkg.sv
hdl/swtg_if.sv
hdl/swtg_ctrl.sv
hdl/swtg_dp.sv
hdl/square_wave_tone_generator.sv
tb/sv/square_wave_tone_generator_tb.sv
